/* rtl/tsu_pkg.sv */
// shared types and constants for the string unescape block
// no dependencies; used by every file of the block by scoped names
package tsu_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_URI_MODE      = 2'd0;
	localparam logic [1:0] REG_DELIM_CHAR    = 2'd1;
	localparam logic [1:0] REG_MAX_CODEPOINT = 2'd2;

	localparam logic [7:0]  DELIM_RESET    = 8'h22;
	localparam logic [31:0] MAXCP_RESET    = 32'h0010_FFFF;
	localparam logic [31:0] UNICODE_MAX    = 32'h0010_FFFF;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_URI_SPACE   = 3'd1,
		ST_URI_CTRL    = 3'd2,
		ST_PAST_END    = 3'd3,
		ST_BAD_HEX     = 3'd4,
		ST_URI_CP      = 3'd5,
		ST_TOO_LARGE   = 3'd6,
		ST_UNKNOWN_ESC = 3'd7
	} status_t;

	typedef struct packed {
		logic        uri_mode;
		logic [7:0]  delim_char;
		logic [31:0] max_codepoint;
	} cfg_t;

	// words produced by one input byte; word k carries bytes[k]
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            byte_valid;
		status_t         status;
		logic            last;
	} bundle_t;

endpackage

/* rtl/turtle_string_unescape_utf8.sv */
// top level of the backslash-escape string decoder with utf-8 output
// depends on tsu_pkg, tsu_decode and tsu_out
//
// usage
//  - slave stream: one raw byte of the escaped string per word in tdata,
//    tlast on the final byte of the string
//  - master stream: one decoded word per handshake; tdata is the byte,
//    tuser carries byte_valid and the status code, tlast ends the string
//  - an input byte gives zero to four words; the first shows on the master
//    side in the cycle after the byte is taken, the rest follow one per
//    cycle while the receiver is ready
//  - a new byte is taken every cycle while the result register is empty or
//    its final word leaves in that cycle, so plain text and escapes run at
//    one input byte per cycle; a multi-byte utf-8 sequence holds the input
//  - a receiver stall holds the current word and, once the result register
//    is full, drops s_axis_tready; nothing is lost
//  - reset clears the escape state and the result register and loads the
//    registers with their defaults (delimiter 0x22, max code point 0x10ffff)
//  - registers are written through cfg_wen/cfg_index/cfg_wdata; the user must
//    write them only while the block is idle, which the block does not enforce
module turtle_string_unescape_utf8 (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [3:0]  m_axis_tuser,   // [0] byte_valid, [3:1] status
	output logic        m_axis_tlast
);

	tsu_pkg::cfg_t    cfg_q;
	tsu_pkg::bundle_t bundle;
	logic             emit;
	logic             can_load;
	logic             in_accept;
	logic             byte_valid;
	logic [2:0]       status;

	// configuration registers, written one at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.uri_mode      <= 1'b0;
			cfg_q.delim_char    <= tsu_pkg::DELIM_RESET;
			cfg_q.max_codepoint <= tsu_pkg::MAXCP_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				tsu_pkg::REG_URI_MODE:      cfg_q.uri_mode      <= cfg_wdata[0];
				tsu_pkg::REG_DELIM_CHAR:    cfg_q.delim_char    <= cfg_wdata[7:0];
				tsu_pkg::REG_MAX_CODEPOINT: cfg_q.max_codepoint <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input is taken whenever the result register can take this byte's words
	assign s_axis_tready = can_load;
	assign in_accept     = s_axis_tvalid && can_load;

	tsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.in_byte (s_axis_tdata),
		.in_last (s_axis_tlast),
		.cfg     (cfg_q),
		.emit    (emit),
		.bundle  (bundle)
	);

	// bytes that give no word only move the escape state
	tsu_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_accept && emit),
		.bundle       (bundle),
		.can_load     (can_load),
		.m_valid      (m_axis_tvalid),
		.m_ready      (m_axis_tready),
		.m_byte       (m_axis_tdata),
		.m_byte_valid (byte_valid),
		.m_status     (status),
		.m_last       (m_axis_tlast)
	);

	assign m_axis_tuser = {status, byte_valid};

endmodule

/* rtl/tsu_decode.sv */
// escape decoder: escape state registers and the per-byte decode logic
// depends on tsu_pkg
module tsu_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  tsu_pkg::cfg_t    cfg,
	output logic             emit,
	output tsu_pkg::bundle_t bundle
);

	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_ESC  = 2'd1,
		PH_HEX  = 2'd2
	} phase_t;

	phase_t      phase_q, phase_n;
	logic        long_q, long_n;
	logic [3:0]  cnt_q, cnt_n;
	logic [31:0] acc_q, acc_n;
	logic        halted_q, halted_n;

	logic             fatal;
	tsu_pkg::status_t fatal_st;
	logic [7:0]       ctl;
	logic             is_ctl;
	logic             is_lit;
	logic [4:0]       hex;
	logic [31:0]      acc_shift;
	logic [3:0]       cnt_inc;
	logic [3:0]       need;
	logic [31:0]      cp;

	// bit 4 set when the byte is not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39)
			v = {1'b0, c[3:0]};
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			v = {1'b0, c[3:0] + 4'd9};
		return v;
	endfunction

	always_comb begin
		case (in_byte)
			8'h6E: begin ctl = 8'h0A; is_ctl = 1'b1; end
			8'h72: begin ctl = 8'h0D; is_ctl = 1'b1; end
			8'h74: begin ctl = 8'h09; is_ctl = 1'b1; end
			8'h62: begin ctl = 8'h08; is_ctl = 1'b1; end
			8'h66: begin ctl = 8'h0C; is_ctl = 1'b1; end
			default: begin ctl = 8'h00; is_ctl = 1'b0; end
		endcase
		is_lit = (in_byte == 8'h5C) || (in_byte == cfg.delim_char) ||
			(in_byte inside {8'h2D, 8'h5F, 8'h7E, 8'h2E, 8'h21, 8'h24, 8'h26,
			8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h2F,
			8'h3F, 8'h23, 8'h40, 8'h25});
		hex       = hex_value(in_byte);
		acc_shift = {acc_q[27:0], hex[3:0]};
		cnt_inc   = cnt_q + 4'd1;
		need      = long_q ? 4'd8 : 4'd4;
		cp        = acc_shift;
	end

	always_comb begin
		phase_n  = phase_q;
		long_n   = long_q;
		cnt_n    = cnt_q;
		acc_n    = acc_q;
		halted_n = halted_q;
		fatal    = 1'b0;
		fatal_st = tsu_pkg::ST_OK;
		emit     = 1'b0;
		bundle   = '0;

		if (halted_q) begin
			if (in_last) begin
				halted_n = 1'b0;
				phase_n  = PH_TEXT;
				long_n   = 1'b0;
				cnt_n    = 4'd0;
				acc_n    = 32'd0;
			end
		end else begin
			case (phase_q)
				PH_ESC: begin
					phase_n = PH_TEXT;
					if (is_ctl) begin
						if (cfg.uri_mode) begin
							fatal    = 1'b1;
							fatal_st = tsu_pkg::ST_URI_CTRL;
						end else begin
							emit              = 1'b1;
							bundle.bytes[0]   = ctl;
							bundle.byte_valid = 1'b1;
							bundle.last       = in_last;
						end
					end else if (is_lit) begin
						emit              = 1'b1;
						bundle.bytes[0]   = in_byte;
						bundle.byte_valid = 1'b1;
						bundle.last       = in_last;
					end else if (in_byte == 8'h75 || in_byte == 8'h55) begin
						if (in_last) begin
							fatal    = 1'b1;
							fatal_st = tsu_pkg::ST_PAST_END;
						end else begin
							phase_n = PH_HEX;
							long_n  = (in_byte == 8'h55);
							cnt_n   = 4'd0;
							acc_n   = 32'd0;
						end
					end else begin
						emit          = 1'b1;
						bundle.status = tsu_pkg::ST_UNKNOWN_ESC;
						bundle.last   = in_last;
					end
				end
				PH_HEX: begin
					if (hex[4]) begin
						fatal    = 1'b1;
						fatal_st = tsu_pkg::ST_BAD_HEX;
					end else if (cnt_inc < need) begin
						if (in_last) begin
							fatal    = 1'b1;
							fatal_st = tsu_pkg::ST_PAST_END;
						end else begin
							acc_n = acc_shift;
							cnt_n = cnt_inc;
						end
					end else begin
						phase_n = PH_TEXT;
						long_n  = 1'b0;
						cnt_n   = 4'd0;
						acc_n   = 32'd0;
						if (cfg.uri_mode && (cp == 32'h20 || cp == 32'h3C || cp == 32'h3E))
						begin
							fatal    = 1'b1;
							fatal_st = tsu_pkg::ST_URI_CP;
						end else if (cp > cfg.max_codepoint || cp > tsu_pkg::UNICODE_MAX)
						begin
							fatal    = 1'b1;
							fatal_st = tsu_pkg::ST_TOO_LARGE;
						end else begin
							emit              = 1'b1;
							bundle.byte_valid = 1'b1;
							bundle.last       = in_last;
							if (cp < 32'h80) begin
								bundle.bytes[0] = {1'b0, cp[6:0]};
								bundle.last_idx = 2'd0;
							end else if (cp < 32'h800) begin
								bundle.bytes[0] = {3'b110, cp[10:6]};
								bundle.bytes[1] = {2'b10, cp[5:0]};
								bundle.last_idx = 2'd1;
							end else if (cp < 32'h10000) begin
								bundle.bytes[0] = {4'b1110, cp[15:12]};
								bundle.bytes[1] = {2'b10, cp[11:6]};
								bundle.bytes[2] = {2'b10, cp[5:0]};
								bundle.last_idx = 2'd2;
							end else begin
								bundle.bytes[0] = {5'b11110, cp[20:18]};
								bundle.bytes[1] = {2'b10, cp[17:12]};
								bundle.bytes[2] = {2'b10, cp[11:6]};
								bundle.bytes[3] = {2'b10, cp[5:0]};
								bundle.last_idx = 2'd3;
							end
						end
					end
				end
				default: begin
					phase_n = PH_TEXT;
					if (in_byte == 8'h5C) begin
						if (in_last) begin
							fatal    = 1'b1;
							fatal_st = tsu_pkg::ST_PAST_END;
						end else begin
							phase_n = PH_ESC;
						end
					end else if (cfg.uri_mode && in_byte == 8'h20) begin
						fatal    = 1'b1;
						fatal_st = tsu_pkg::ST_URI_SPACE;
					end else begin
						emit              = 1'b1;
						bundle.bytes[0]   = in_byte;
						bundle.byte_valid = 1'b1;
						bundle.last       = in_last;
					end
				end
			endcase

			if (fatal) begin
				phase_n  = PH_TEXT;
				long_n   = 1'b0;
				cnt_n    = 4'd0;
				acc_n    = 32'd0;
				halted_n = !in_last;
				emit     = 1'b1;
				bundle   = '0;
				bundle.status = fatal_st;
				bundle.last   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TEXT;
			long_q   <= 1'b0;
			cnt_q    <= 4'd0;
			acc_q    <= 32'd0;
			halted_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_n;
			long_q   <= long_n;
			cnt_q    <= cnt_n;
			acc_q    <= acc_n;
			halted_q <= halted_n;
		end
	end

endmodule

/* rtl/tsu_out.sv */
// result register and word serializer: holds the words of one input byte
// and hands them out one per cycle while m_ready is high; depends on tsu_pkg
module tsu_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  tsu_pkg::bundle_t bundle,
	output logic             can_load,
	output logic             m_valid,
	input  logic             m_ready,
	output logic [7:0]       m_byte,
	output logic             m_byte_valid,
	output logic [2:0]       m_status,
	output logic             m_last
);

	tsu_pkg::bundle_t bun_s1;
	logic             busy_s1;
	logic [1:0]       idx_q;
	logic             final_word;
	logic             take;

	assign final_word   = (idx_q == bun_s1.last_idx);
	assign take         = busy_s1 && m_ready;
	assign can_load     = !busy_s1 || (take && final_word);
	assign m_valid      = busy_s1;
	assign m_byte       = bun_s1.bytes[idx_q];
	assign m_byte_valid = bun_s1.byte_valid;
	assign m_status     = bun_s1.status;
	assign m_last       = final_word && bun_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			busy_s1 <= 1'b1;
			idx_q   <= 2'd0;
		end else if (take) begin
			if (final_word) begin
				busy_s1 <= 1'b0;
				idx_q   <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			bun_s1 <= bundle;
	end

endmodule
